>>> design/spq_pkg.sv
// Package for the stable minimum priority queue core.
// Holds the word types, operation and status codes, and the default depth.
// No dependencies; every other file of the block imports it.
package spq_pkg;

  localparam int unsigned SpqDepth = 16;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned TagW     = 16;
  localparam int unsigned OccW     = 5;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_PUSH_OK   = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [1:0] ST_POP_OK    = 2'd2;
  localparam logic [1:0] ST_POP_EMPTY = 2'd3;

  typedef struct packed {
    logic                   operation;
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [TagW-1:0] popped_tag;
    logic [OccW-1:0] occupancy;
  } out_word_t;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [TagW-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t entry;
  } spq_cmd_t;

endpackage

>>> design/spq_cell.sv
// One slot of the sorted queue: holds an entry and its valid bit.
// Shifts toward the tail on an insert and toward the head on a removal.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spq_cmd_t cmd_i,
  input  logic     prev_ins_i,
  input  logic     prev_valid_i,
  input  entry_t   prev_entry_i,
  input  logic     next_valid_i,
  input  entry_t   next_entry_i,
  output logic     valid_o,
  output logic     ins_o,
  output entry_t   entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   greater;

  // The new entry lands in the first slot that is empty or holds a
  // strictly greater key, so equal keys keep their arrival order.
  assign greater = valid_q && (entry_q.key > cmd_i.entry.key);
  assign ins_o   = !valid_q || greater;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.push && ins_o) begin
      valid_d = prev_valid_i;
      entry_d = prev_ins_i ? prev_entry_i : cmd_i.entry;
    end else if (cmd_i.pop) begin
      valid_d = next_valid_i;
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

>>> design/stable_min_priority_queue_core.sv
// Stable bounded minimum priority queue built as a chain of sorted cells.
//
// Usage: drive in_word_i and raise start. A word is taken at every rising
// edge where start is high and busy is low; busy stays low, so a new word
// can follow in every cycle. A push stores a signed Q16.16 key and a tag;
// a pop removes the entry with the smallest key, the earliest pushed among
// equal keys. Each word yields exactly one result word on result_o, marked
// by done_o for one cycle, in the cycle after it was taken. Status reports a
// stored push, a push rejected because the queue is full, a delivered pop
// with its tag, or a pop of an empty queue; occupancy gives the entry count
// after the word. On an insert every cell compares its key with the new key
// in parallel; on an insert or removal each cell takes its neighbor's
// entry at the next edge. Reset empties the queue by clearing the valid
// bits of all cells; the stored entries are not cleared. The receiver
// cannot stall, so a result must be captured in the cycle done_o is high.
module stable_min_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned DEPTH = SpqDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  output logic      done_o,
  output out_word_t result_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            valid_w [DEPTH];
  logic            ins_w   [DEPTH];
  entry_t          entry_w [DEPTH];
  logic [DEPTH-1:0] valid_vec;

  spq_cmd_t        cmd;
  logic            accept, full, empty;
  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  out_word_t       result_q, result_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = valid_vec[DEPTH-1];
  assign empty  = !valid_vec[0];

  assign cmd.push        = accept && (in_word_i.operation == OP_PUSH) && !full;
  assign cmd.pop         = accept && (in_word_i.operation == OP_POP) && !empty;
  assign cmd.entry.key   = in_word_i.key;
  assign cmd.entry.tag   = in_word_i.tag;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_ins, prev_valid, next_valid;
    entry_t prev_entry, next_entry;

    if (i == 0) begin : g_head
      assign prev_ins   = 1'b0;
      assign prev_valid = 1'b1;
      assign prev_entry = cmd.entry;
    end else begin : g_body
      assign prev_ins   = ins_w[i-1];
      assign prev_valid = valid_w[i-1];
      assign prev_entry = entry_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = entry_w[i];
    end else begin : g_mid
      assign next_valid = valid_w[i+1];
      assign next_entry = entry_w[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_ins_i   (prev_ins),
      .prev_valid_i (prev_valid),
      .prev_entry_i (prev_entry),
      .next_valid_i (next_valid),
      .next_entry_i (next_entry),
      .valid_o      (valid_w[i]),
      .ins_o        (ins_w[i]),
      .entry_o      (entry_w[i])
    );

    assign valid_vec[i] = valid_w[i];
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    result_d.popped_tag = '0;
    result_d.occupancy  = OccW'(count_d);
    if (in_word_i.operation == OP_PUSH) begin
      result_d.status = full ? ST_PUSH_FULL : ST_PUSH_OK;
    end else if (empty) begin
      result_d.status = ST_POP_EMPTY;
    end else begin
      result_d.status     = ST_POP_OK;
      result_d.popped_tag = entry_w[0].tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef NO_ASSERTIONS
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("Valid cells do not form a contiguous prefix.");

  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("Entry count disagrees with the valid cells.");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("Accepted word produced no result.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("Removal did not lower the entry count.");
`endif

endmodule
